/* src/piecewise_linear_interp_assert.svh */
// Assertion macros shared by the piecewise linear interpolator RTL.
`ifndef PIECEWISE_LINEAR_INTERP_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLI_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/pli_pkg.sv */
// Types and constants of the piecewise linear interpolator.
package pli_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int INDEX_W   = 6;
    localparam int COUNT_W   = 7;

    localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [1:0] SIDE_INSIDE = 2'd0;
    localparam logic [1:0] SIDE_BELOW  = 2'd1;
    localparam logic [1:0] SIDE_ABOVE  = 2'd2;

    // Register index as decoded from paddr[2].
    localparam logic REG_POINT_COUNT = 1'b0;

    localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = 7'd2;

    typedef struct packed {
        logic                      kind;
        logic [INDEX_W-1:0]        point_index;
        logic signed [DATA_W-1:0]  position;
        logic signed [DATA_W-1:0]  point_value;
    } pli_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  result_value;
        logic [INDEX_W-1:0]        segment;
        logic [1:0]                clamp_side;
    } pli_rsp_t;

endpackage

/* src/pli_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/piecewise_linear_interp.sv */
// Piecewise linear interpolator over a non-uniform grid held in block RAM.
//
// Items enter on request when start is high and busy is low. A write item
// (kind zero) stores one grid point and its value and gives no result; busy
// stays low, so items may follow back to back.
// A query item raises busy until its result has been formed. The result is
// shown on response for exactly one cycle with done high, from the same edge
// at which busy falls; the receiver cannot stall it.
// A query first reads the lowest and highest grid points and clamps below or
// above the grid. Otherwise it runs a binary search of at most
// ceil(log2(point_count - 1)) steps, each waiting for the synchronous grid
// RAM read, then a restoring divider that forms the weight one bit at a time
// and one registered multiply. A segment of zero or negative width skips the
// divider and the multiply, and a saturated weight skips the divider. The
// next item can be taken while done is high, since busy has already fallen.
// point_count sits at APB byte address 0 and the user must see that it is
// written only while idle; the block itself does not enforce this. Reset sets
// point_count to 2 and returns the control to idle; the grid and value RAMs
// are not cleared and must be written before they are queried.
`include "piecewise_linear_interp_assert.svh"

module piecewise_linear_interp #(
    parameter int MAX_POINTS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pli_pkg::pli_req_t request,
    output logic              done,
    output pli_pkg::pli_rsp_t response,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    import pli_pkg::*;

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CMPW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
    localparam int CNTW = $clog2(FRAC_BITS);
    localparam int PW   = DATA_W + FRAC_BITS + 3;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD0  = 4'd1;
    localparam logic [3:0] S_CHK0 = 4'd2;
    localparam logic [3:0] S_CHKN = 4'd3;
    localparam logic [3:0] S_SADR = 4'd4;
    localparam logic [3:0] S_SCMP = 4'd5;
    localparam logic [3:0] S_FADR = 4'd6;
    localparam logic [3:0] S_FLO  = 4'd7;
    localparam logic [3:0] S_FHI  = 4'd8;
    localparam logic [3:0] S_PREP = 4'd9;
    localparam logic [3:0] S_DIV  = 4'd10;
    localparam logic [3:0] S_MUL  = 4'd11;
    localparam logic [3:0] S_ADD  = 4'd12;

    logic [3:0]                state_reg, state_next;
    logic                      done_reg, done_next;
    logic [COUNT_W-1:0]        point_count_reg, point_count_next;

    pli_rsp_t                  response_reg, response_next;
    logic signed [DATA_W-1:0]  pos_reg, pos_next;
    logic [AW-1:0]             addr_reg, addr_next;
    logic [AW-1:0]             lo_reg, lo_next;
    logic [AW-1:0]             hi_reg, hi_next;
    logic signed [DATA_W-1:0]  x0_reg, x0_next;
    logic signed [DATA_W-1:0]  v0_reg, v0_next;
    logic signed [DATA_W:0]    dx_reg, dx_next;
    logic signed [DATA_W:0]    dv_reg, dv_next;
    logic [DATA_W:0]           rem_reg, rem_next;
    logic [FRAC_BITS:0]        t_reg, t_next;
    logic [CNTW-1:0]           cnt_reg, cnt_next;
    logic signed [PW-1:0]      prod_reg, prod_next;

    logic                      accept;
    logic                      write_en;
    logic [DATA_W-1:0]         grid_rdata;
    logic [DATA_W-1:0]         value_rdata;
    logic [CMPW-1:0]           count_wide;
    logic [AW-1:0]             last_index;
    logic [AW-1:0]             nlo;
    logic [AW-1:0]             nhi;
    logic [AW:0]               nsum;
    logic [AW-1:0]             nmid;
    logic [DATA_W+1:0]         rem_shift;
    logic [DATA_W+1:0]         dx_ext;
    logic signed [PW-1:0]      prod_shift;

    assign accept   = start && !busy;
    assign write_en = accept && (request.kind == KIND_WRITE)
                      && (CMPW'(request.point_index) < CMPW'(MAX_POINTS));

    pli_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_POINTS)
    ) u_grid_ram (
        .clk   (clk),
        .we    (write_en),
        .waddr (AW'(request.point_index)),
        .wdata (request.position),
        .raddr (addr_reg),
        .rdata (grid_rdata)
    );

    pli_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_POINTS)
    ) u_value_ram (
        .clk   (clk),
        .we    (write_en),
        .waddr (AW'(request.point_index)),
        .wdata (request.point_value),
        .raddr (addr_reg),
        .rdata (value_rdata)
    );

    // Point count limited to the range 2..MAX_POINTS, then less one.
    always_comb
    begin
        count_wide = CMPW'(point_count_reg);
        if (count_wide < CMPW'(2))
        begin
            last_index = AW'(1);
        end
        else if (count_wide > CMPW'(MAX_POINTS))
        begin
            last_index = AW'(MAX_POINTS - 1);
        end
        else
        begin
            last_index = AW'(count_wide - CMPW'(1));
        end
    end

    // Search bounds after this cycle's compare, and the next probe between them.
    always_comb
    begin
        if (state_reg == S_SCMP)
        begin
            if ($signed(grid_rdata) > pos_reg)
            begin
                nlo = lo_reg;
                nhi = addr_reg;
            end
            else
            begin
                nlo = addr_reg + AW'(1);
                nhi = hi_reg;
            end
        end
        else
        begin
            nlo = AW'(1);
            nhi = hi_reg;
        end
        nsum = {1'b0, nlo} + {1'b0, nhi};
        nmid = nsum[AW:1];
    end

    assign rem_shift  = {rem_reg, 1'b0};
    assign dx_ext     = {1'b0, $unsigned(dx_reg)};
    assign prod_shift = prod_reg >>> FRAC_BITS;

    always_comb
    begin
        state_next       = state_reg;
        done_next        = 1'b0;
        point_count_next = point_count_reg;
        response_next    = response_reg;
        pos_next         = pos_reg;
        addr_next        = addr_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        x0_next          = x0_reg;
        v0_next          = v0_reg;
        dx_next          = dx_reg;
        dv_next          = dv_reg;
        rem_next         = rem_reg;
        t_next           = t_reg;
        cnt_next         = cnt_reg;
        prod_next        = prod_reg;

        if (psel && penable && pwrite && pready && (paddr[2] == REG_POINT_COUNT))
        begin
            point_count_next = pwdata[COUNT_W-1:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (request.kind == KIND_QUERY))
                begin
                    pos_next   = request.position;
                    addr_next  = '0;
                    state_next = S_RD0;
                end
            end
            S_RD0:
            begin
                hi_next    = last_index;
                addr_next  = last_index;
                state_next = S_CHK0;
            end
            S_CHK0:
            begin
                if (pos_reg <= $signed(grid_rdata))
                begin
                    response_next.result_value = value_rdata;
                    response_next.segment      = INDEX_W'(1);
                    response_next.clamp_side   = SIDE_BELOW;
                    done_next                  = 1'b1;
                    state_next                 = S_IDLE;
                end
                else
                begin
                    state_next = S_CHKN;
                end
            end
            S_CHKN, S_SCMP:
            begin
                if ((state_reg == S_CHKN) && (pos_reg >= $signed(grid_rdata)))
                begin
                    response_next.result_value = value_rdata;
                    response_next.segment      = INDEX_W'(hi_reg);
                    response_next.clamp_side   = SIDE_ABOVE;
                    done_next                  = 1'b1;
                    state_next                 = S_IDLE;
                end
                else if (nlo < nhi)
                begin
                    lo_next    = nlo;
                    hi_next    = nhi;
                    addr_next  = nmid;
                    state_next = S_SADR;
                end
                else
                begin
                    lo_next    = nlo;
                    addr_next  = nlo - AW'(1);
                    state_next = S_FADR;
                end
            end
            S_SADR:
            begin
                state_next = S_SCMP;
            end
            S_FADR:
            begin
                addr_next  = lo_reg;
                state_next = S_FLO;
            end
            S_FLO:
            begin
                x0_next    = grid_rdata;
                v0_next    = value_rdata;
                state_next = S_FHI;
            end
            S_FHI:
            begin
                dx_next    = {grid_rdata[DATA_W-1], grid_rdata} - {x0_reg[DATA_W-1], x0_reg};
                rem_next   = {pos_reg[DATA_W-1], pos_reg} - {x0_reg[DATA_W-1], x0_reg};
                dv_next    = {value_rdata[DATA_W-1], value_rdata} - {v0_reg[DATA_W-1], v0_reg};
                state_next = S_PREP;
            end
            S_PREP:
            begin
                response_next.segment    = INDEX_W'(lo_reg);
                response_next.clamp_side = SIDE_INSIDE;
                if (dx_reg[DATA_W] || (dx_reg == '0))
                begin
                    // Degenerate segment: the lower value stands.
                    response_next.result_value = v0_reg;
                    done_next                  = 1'b1;
                    state_next                 = S_IDLE;
                end
                else if (rem_reg[DATA_W])
                begin
                    t_next     = '0;
                    state_next = S_MUL;
                end
                else if (rem_reg >= $unsigned(dx_reg))
                begin
                    t_next     = FRAC_ONE;
                    state_next = S_MUL;
                end
                else
                begin
                    t_next     = '0;
                    cnt_next   = CNTW'(FRAC_BITS - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // One quotient bit per cycle; the remainder stays below dx.
                if (rem_shift >= dx_ext)
                begin
                    rem_next = (DATA_W + 1)'(rem_shift - dx_ext);
                    t_next   = {t_reg[FRAC_BITS-1:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[DATA_W:0];
                    t_next   = {t_reg[FRAC_BITS-1:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg - CNTW'(1);
                end
            end
            S_MUL:
            begin
                prod_next  = dv_reg * $signed({1'b0, t_reg});
                state_next = S_ADD;
            end
            S_ADD:
            begin
                response_next.result_value = prod_shift[DATA_W-1:0] + v0_reg;
                done_next                  = 1'b1;
                state_next                 = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            done_reg        <= 1'b0;
            point_count_reg <= POINT_COUNT_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            done_reg        <= done_next;
            point_count_reg <= point_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        response_reg <= response_next;
        pos_reg      <= pos_next;
        addr_reg     <= addr_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        x0_reg       <= x0_next;
        v0_reg       <= v0_next;
        dx_reg       <= dx_next;
        dv_reg       <= dv_next;
        rem_reg      <= rem_next;
        t_reg        <= t_next;
        cnt_reg      <= cnt_next;
        prod_reg     <= prod_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign response = response_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_POINT_COUNT) ? 32'(point_count_reg) : '0;

    `PLI_ASSERT_HOLDS(a_done_when_idle, done_reg, state_reg == S_IDLE,
        "result strobe raised while a query is still in progress")
    `PLI_ASSERT_NEXT(a_query_goes_busy, accept && (request.kind == KIND_QUERY), busy,
        "accepted query did not start work")
    `PLI_ASSERT_NEXT(a_write_no_result, accept && (request.kind == KIND_WRITE), !done_reg,
        "write item produced a result")
    `PLI_ASSERT_HOLDS(a_probe_in_bounds, (state_reg == S_SADR) || (state_reg == S_SCMP),
        (lo_reg <= addr_reg) && (addr_reg < hi_reg),
        "binary search probe outside its bounds")
    `PLI_ASSERT_HOLDS(a_div_remainder, state_reg == S_DIV, rem_reg < $unsigned(dx_reg),
        "divider remainder not below the segment width")

endmodule
